@@ src/hdpp_pkg.sv @@
// ----------------------------------------------------------------------------
// hdpp_pkg
// Shared constants and register codes for the Huber-ROF dual proximal step.
// ----------------------------------------------------------------------------
package hdpp_pkg;

  localparam int REG_BITS          = 32;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int DEFAULT_DATA_BITS = 32;
  localparam int DEFAULT_FRAC_BITS = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_STEP_SIGMA  = 2'd0,
    REG_HUBER_ALPHA = 2'd1
  } cfg_reg_e;

endpackage

@@ src/huber_dual_prox_projection_top.sv @@
// ----------------------------------------------------------------------------
// huber_dual_prox_projection_top
// Huber-ROF dual proximal step: projects y/(1+sigma*alpha) onto the unit ball.
// ----------------------------------------------------------------------------
// One item enters per cycle while the output is taken. The square root
// resolves one root bit per stage and the divider resolves one quotient bit
// per stage; both are fully pipelined, so the sustained rate is one item per
// cycle. When the output is not taken the whole pipeline holds. The factor
// k = 1 + sigma*alpha is registered from the sigma and alpha registers and
// is read at the divisor select stage.
module huber_dual_prox_projection_top #(
  parameter int DATA_BITS = hdpp_pkg::DEFAULT_DATA_BITS,
  parameter int FRAC_BITS = hdpp_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hdpp_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [hdpp_pkg::REG_BITS-1:0]       cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [DATA_BITS-1:0]         dual_first_i,
  input  logic signed [DATA_BITS-1:0]         dual_second_i,
  input  logic                                frame_end_in_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [FRAC_BITS+1:0]         prox_first_o,
  output logic signed [FRAC_BITS+1:0]         prox_second_o,
  output logic                                frame_end_out_o
);

  import hdpp_pkg::*;

  localparam int HB    = (DATA_BITS + 1) / 2;       // low half width
  localparam int HIB   = DATA_BITS - HB;            // high half width
  localparam int SW    = 2 * DATA_BITS;             // sum of squares width
  localparam int PW    = 2 * REG_BITS;              // sigma*alpha product
  localparam int KW    = PW - FRAC_BITS + 1;        // k width
  localparam int DW    = (KW > DATA_BITS) ? KW : DATA_BITS;
  localparam int QW    = FRAC_BITS + 1;             // unsigned quotient incl 1.0
  localparam int OW    = FRAC_BITS + 2;

  typedef struct packed {
    logic [DATA_BITS-1:0] mag1;
    logic [DATA_BITS-1:0] mag2;
    logic                 neg1;
    logic                 neg2;
    logic                 fe;
  } ctx_t;

  typedef struct packed {
    logic [2*HIB-1:0]     hh;
    logic [DATA_BITS-1:0] hl;
    logic [2*HB-1:0]      ll;
  } sq_part_t;

  typedef struct packed {
    logic [SW-1:0]        rem;
    logic [DATA_BITS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DW-1:0]        dvs;
    logic                 sat1;
    logic                 sat2;
    logic [DW-1:0]        r1;
    logic [DW-1:0]        r2;
    logic [FRAC_BITS-1:0] q1;
    logic [FRAC_BITS-1:0] q2;
  } div_t;

  // ---------------------------------------------------------------------------
  // configuration registers and k
  // ---------------------------------------------------------------------------
  logic [REG_BITS-1:0] sigma_q, alpha_q;
  logic [KW-1:0]       k_q;
  logic [PW-1:0]       sa_prod;

  assign cfg_ready_o = 1'b1;
  assign sa_prod     = PW'(sigma_q) * PW'(alpha_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= REG_BITS'(64'd1 << FRAC_BITS);
      alpha_q <= '0;
      k_q     <= KW'(64'd1 << FRAC_BITS);
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_STEP_SIGMA:  sigma_q <= cfg_data_i;
          REG_HUBER_ALPHA: alpha_q <= cfg_data_i;
          default: ;
        endcase
      end
      k_q <= KW'(sa_prod >> FRAC_BITS) + KW'(64'd1 << FRAC_BITS);
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: the whole pipe moves when the output slot is free
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------------
  // stage 0: magnitudes
  // ---------------------------------------------------------------------------
  ctx_t ctx0_d, ctx0_q;
  logic v0_q;

  always_comb begin
    ctx0_d.neg1 = dual_first_i[DATA_BITS-1];
    ctx0_d.neg2 = dual_second_i[DATA_BITS-1];
    ctx0_d.mag1 = ctx0_d.neg1 ? (~dual_first_i + DATA_BITS'(1)) : dual_first_i;
    ctx0_d.mag2 = ctx0_d.neg2 ? (~dual_second_i + DATA_BITS'(1)) : dual_second_i;
    ctx0_d.fe   = frame_end_in_i;
  end

  // ---------------------------------------------------------------------------
  // stage 1: partial products of the squares
  // ---------------------------------------------------------------------------
  sq_part_t p1_d, p2_d, p1_q, p2_q;
  ctx_t     ctx1_q;
  logic     v1_q;

  always_comb begin
    p1_d.hh = (2*HIB)'(ctx0_q.mag1[DATA_BITS-1:HB]) * (2*HIB)'(ctx0_q.mag1[DATA_BITS-1:HB]);
    p1_d.hl = DATA_BITS'(ctx0_q.mag1[DATA_BITS-1:HB]) * DATA_BITS'(ctx0_q.mag1[HB-1:0]);
    p1_d.ll = (2*HB)'(ctx0_q.mag1[HB-1:0]) * (2*HB)'(ctx0_q.mag1[HB-1:0]);
    p2_d.hh = (2*HIB)'(ctx0_q.mag2[DATA_BITS-1:HB]) * (2*HIB)'(ctx0_q.mag2[DATA_BITS-1:HB]);
    p2_d.hl = DATA_BITS'(ctx0_q.mag2[DATA_BITS-1:HB]) * DATA_BITS'(ctx0_q.mag2[HB-1:0]);
    p2_d.ll = (2*HB)'(ctx0_q.mag2[HB-1:0]) * (2*HB)'(ctx0_q.mag2[HB-1:0]);
  end

  // ---------------------------------------------------------------------------
  // stage 2: squares, stage 3: sum of squares
  // ---------------------------------------------------------------------------
  logic [SW-1:0] sq1_d, sq2_d, sq1_q, sq2_q, sum_d, sum_q;
  ctx_t          ctx2_q, ctx3_q;
  logic          v2_q, v3_q;

  always_comb begin
    sq1_d = (SW'(p1_q.hh) << (2*HB)) + (SW'(p1_q.hl) << (HB+1)) + SW'(p1_q.ll);
    sq2_d = (SW'(p2_q.hh) << (2*HB)) + (SW'(p2_q.hl) << (HB+1)) + SW'(p2_q.ll);
    sum_d = sq1_q + sq2_q;
  end

  // ---------------------------------------------------------------------------
  // square root: one root bit per stage, remainder kept as x - root^2
  // ---------------------------------------------------------------------------
  sqrt_t sr_in [DATA_BITS];
  sqrt_t sr_d  [DATA_BITS];
  sqrt_t sr_q  [DATA_BITS];
  ctx_t  ctx_sr_q [DATA_BITS];
  logic  v_sr_q   [DATA_BITS];

  always_comb begin
    for (int s = 0; s < DATA_BITS; s++) begin
      logic [SW:0] trial;
      if (s == 0) begin
        sr_in[s].rem  = sum_q;
        sr_in[s].root = '0;
      end else begin
        sr_in[s] = sr_q[s-1];
      end
      // (2*root + 2^b) * 2^b with b = DATA_BITS-1-s
      trial = (((SW+1)'(sr_in[s].root) << 1) | ((SW+1)'(1) << (DATA_BITS-1-s)))
              << (DATA_BITS-1-s);
      sr_d[s] = sr_in[s];
      if (trial <= (SW+1)'(sr_in[s].rem)) begin
        sr_d[s].rem  = sr_in[s].rem - SW'(trial);
        sr_d[s].root = sr_in[s].root | (DATA_BITS'(1) << (DATA_BITS-1-s));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // divisor select: d = max(k, norm), saturation when the magnitude reaches d
  // ---------------------------------------------------------------------------
  div_t dp_d;
  ctx_t ctx_dp_q;
  logic v_dp_q;
  div_t dv_in [FRAC_BITS];
  div_t dv_d  [FRAC_BITS];
  div_t dv_q  [FRAC_BITS];
  ctx_t ctx_dv_q [FRAC_BITS];
  logic v_dv_q   [FRAC_BITS];
  div_t dp_q;

  always_comb begin
    logic [DW-1:0] nrm, kk;
    nrm = DW'(sr_q[DATA_BITS-1].root);
    kk  = DW'(k_q);
    dp_d.dvs  = (nrm > kk) ? nrm : kk;
    dp_d.sat1 = DW'(ctx_sr_q[DATA_BITS-1].mag1) >= dp_d.dvs;
    dp_d.sat2 = DW'(ctx_sr_q[DATA_BITS-1].mag2) >= dp_d.dvs;
    dp_d.r1   = DW'(ctx_sr_q[DATA_BITS-1].mag1);
    dp_d.r2   = DW'(ctx_sr_q[DATA_BITS-1].mag2);
    dp_d.q1   = '0;
    dp_d.q2   = '0;
  end

  // ---------------------------------------------------------------------------
  // restoring division: one quotient bit per stage for both components
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int s = 0; s < FRAC_BITS; s++) begin
      logic [DW:0] t1, t2;
      dv_in[s] = (s == 0) ? dp_q : dv_q[s-1];
      dv_d[s]  = dv_in[s];
      t1 = {dv_in[s].r1, 1'b0};
      t2 = {dv_in[s].r2, 1'b0};
      dv_d[s].q1 = {dv_in[s].q1[FRAC_BITS-2:0], 1'b0};
      dv_d[s].q2 = {dv_in[s].q2[FRAC_BITS-2:0], 1'b0};
      dv_d[s].r1 = DW'(t1);
      dv_d[s].r2 = DW'(t2);
      if (t1 >= {1'b0, dv_in[s].dvs}) begin
        dv_d[s].r1    = DW'(t1 - {1'b0, dv_in[s].dvs});
        dv_d[s].q1[0] = 1'b1;
      end
      if (t2 >= {1'b0, dv_in[s].dvs}) begin
        dv_d[s].r2    = DW'(t2 - {1'b0, dv_in[s].dvs});
        dv_d[s].q2[0] = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output: saturate, restore sign
  // ---------------------------------------------------------------------------
  logic [QW-1:0] uq1, uq2;
  logic [OW-1:0] o1_d, o2_d;
  ctx_t          cl;
  div_t          dl;

  always_comb begin
    cl   = ctx_dv_q[FRAC_BITS-1];
    dl   = dv_q[FRAC_BITS-1];
    uq1  = dl.sat1 ? (QW'(1) << FRAC_BITS) : {1'b0, dl.q1};
    uq2  = dl.sat2 ? (QW'(1) << FRAC_BITS) : {1'b0, dl.q2};
    o1_d = cl.neg1 ? (OW'(0) - OW'(uq1)) : OW'(uq1);
    o2_d = cl.neg2 ? (OW'(0) - OW'(uq2)) : OW'(uq2);
  end

  // ---------------------------------------------------------------------------
  // valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v_dp_q      <= 1'b0;
      out_valid_o <= 1'b0;
      for (int s = 0; s < DATA_BITS; s++) v_sr_q[s] <= 1'b0;
      for (int s = 0; s < FRAC_BITS; s++) v_dv_q[s] <= 1'b0;
    end else if (adv) begin
      v0_q      <= in_valid_i;
      v1_q      <= v0_q;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v_sr_q[0] <= v3_q;
      for (int s = 1; s < DATA_BITS; s++) v_sr_q[s] <= v_sr_q[s-1];
      v_dp_q    <= v_sr_q[DATA_BITS-1];
      v_dv_q[0] <= v_dp_q;
      for (int s = 1; s < FRAC_BITS; s++) v_dv_q[s] <= v_dv_q[s-1];
      out_valid_o <= v_dv_q[FRAC_BITS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx0_q <= ctx0_d;
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      ctx1_q <= ctx0_q;
      sq1_q  <= sq1_d;
      sq2_q  <= sq2_d;
      ctx2_q <= ctx1_q;
      sum_q  <= sum_d;
      ctx3_q <= ctx2_q;
      for (int s = 0; s < DATA_BITS; s++) sr_q[s] <= sr_d[s];
      ctx_sr_q[0] <= ctx3_q;
      for (int s = 1; s < DATA_BITS; s++) ctx_sr_q[s] <= ctx_sr_q[s-1];
      dp_q     <= dp_d;
      ctx_dp_q <= ctx_sr_q[DATA_BITS-1];
      for (int s = 0; s < FRAC_BITS; s++) dv_q[s] <= dv_d[s];
      ctx_dv_q[0] <= ctx_dp_q;
      for (int s = 1; s < FRAC_BITS; s++) ctx_dv_q[s] <= ctx_dv_q[s-1];
      prox_first_o    <= o1_d;
      prox_second_o   <= o2_d;
      frame_end_out_o <= cl.fe;
    end
  end

endmodule
